/* hdl/rts_pkg.sv */
// shared widths, codes and types of the rssi trilateration solver
package rts_pkg;

  localparam int COORD_W = 16;
  localparam int RSSI_W  = 8;
  localparam int CFG_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 8;

  // working widths, sized from the field ranges
  localparam int T_W     = CFG_W + RSSI_W + 1;
  localparam int D_W     = T_W - FRAC_W;
  localparam int D2_W    = 2 * D_W;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int K_W     = SQ_W + 3;
  localparam int DF_W    = COORD_W + 1;
  localparam int P_W     = COORD_W + DF_W;
  localparam int DEN_W   = P_W + 3;
  localparam int DMAG_W  = DEN_W - 1;
  localparam int N_W     = K_W + DF_W;
  localparam int NMAG_W  = N_W - 1;
  localparam int POS_W   = 32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic [IDX_W-1:0] REG_SLOPE  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_OFFSET = IDX_W'(1);

  localparam logic signed [CFG_W-1:0] SLOPE_RESET  = -24'sd25743;
  localparam logic signed [CFG_W-1:0] OFFSET_RESET = -24'sd1043399;

  typedef struct packed {
    logic [NMAG_W-1:0] nmag_x;
    logic [NMAG_W-1:0] nmag_y;
    logic [DMAG_W-1:0] dmag_x;
    logic [DMAG_W-1:0] dmag_y;
    logic              neg_x;
    logic              neg_y;
    logic [1:0]        st;
  } front_t;

  typedef struct packed {
    logic [DMAG_W-1:0] rem;
    logic [NMAG_W-1:0] num;
    logic [NMAG_W-1:0] q;
    logic [DMAG_W-1:0] d;
  } lane_t;

  typedef struct packed {
    logic       neg_x;
    logic       neg_y;
    logic [1:0] st;
  } meta_t;

endpackage

/* hdl/rts_div_cell.sv */
// one restoring division step, registered toward the next cell
module rts_div_cell import rts_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  lane_t lane_i,
  output lane_t lane_o
);

  logic [DMAG_W:0] r2;
  logic [DMAG_W:0] diff;
  logic            ge;

  always_comb begin
    r2   = {lane_i.rem, lane_i.num[NMAG_W-1]};
    diff = r2 - {1'b0, lane_i.d};
    ge   = (r2 >= {1'b0, lane_i.d});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_o.rem <= ge ? diff[DMAG_W-1:0] : r2[DMAG_W-1:0];
      lane_o.num <= {lane_i.num[NMAG_W-2:0], 1'b0};
      lane_o.q   <= {lane_i.q[NMAG_W-2:0], ge};
      lane_o.d   <= lane_i.d;
    end
  end

endmodule

/* hdl/rts_front.sv */
// distance model, circle terms and cramer numerators and denominators
module rts_front import rts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic signed [COORD_W-1:0] ax [3],
  input  logic signed [COORD_W-1:0] ay [3],
  input  logic signed [RSSI_W-1:0]  ar [3],
  input  logic signed [CFG_W-1:0]   slope,
  input  logic signed [CFG_W-1:0]   offset,
  output logic                     vld_o,
  output front_t                   res_o
);

  // stage 1
  logic                     s1_v, s1_skip;
  logic signed [COORD_W-1:0] s1_x [3];
  logic signed [COORD_W-1:0] s1_y [3];
  logic signed [T_W-1:0]     s1_t [3];
  logic signed [T_W-1:0]     t_c  [3];
  // stage 2
  logic                     s2_v, s2_skip;
  logic signed [K_W-1:0]     s2_k  [3];
  logic signed [DF_W-1:0]    s2_dx [3];
  logic signed [DF_W-1:0]    s2_dy [3];
  logic signed [P_W-1:0]     s2_dp [3];
  logic signed [P_W-1:0]     s2_ep [3];
  logic signed [T_W-1:0]     tr_c  [3];
  logic signed [D_W-1:0]     d_c   [3];
  logic signed [K_W-1:0]     k_c   [3];
  logic signed [DF_W-1:0]    dx_c  [3];
  logic signed [DF_W-1:0]    dy_c  [3];
  // stage 3
  logic                     s3_v, s3_skip;
  logic signed [N_W-1:0]     s3_nx [3];
  logic signed [N_W-1:0]     s3_ny [3];
  logic signed [DEN_W-1:0]   s3_denx, s3_deny;
  // stage 4 combinational
  logic signed [N_W-1:0]     nx_c, ny_c, nxa_c, nya_c;
  logic signed [DEN_W-1:0]   dxa_c, dya_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_c[i] = T_W'(slope) * T_W'(ar[i]) + T_W'(offset);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x    <= ax;
      s1_y    <= ay;
      s1_t    <= t_c;
      s1_skip <= (ax[0] == '0) || (ax[1] == '0) || (ax[2] == '0);
    end
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tr_c[i] = s1_t[i] + (s1_t[i][T_W-1] ? T_W'((1 << FRAC_W) - 1) : T_W'(0));
      d_c[i]  = tr_c[i][T_W-1:FRAC_W];
      k_c[i]  = K_W'(SQ_W'(s1_x[i]) * SQ_W'(s1_x[i]))
              + K_W'(SQ_W'(s1_y[i]) * SQ_W'(s1_y[i]))
              - K_W'(D2_W'(d_c[i]) * D2_W'(d_c[i]));
    end
    dx_c[0] = DF_W'(s1_x[2]) - DF_W'(s1_x[1]);
    dx_c[1] = DF_W'(s1_x[0]) - DF_W'(s1_x[2]);
    dx_c[2] = DF_W'(s1_x[1]) - DF_W'(s1_x[0]);
    dy_c[0] = DF_W'(s1_y[2]) - DF_W'(s1_y[1]);
    dy_c[1] = DF_W'(s1_y[0]) - DF_W'(s1_y[2]);
    dy_c[2] = DF_W'(s1_y[1]) - DF_W'(s1_y[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_skip <= s1_skip;
      s2_k    <= k_c;
      s2_dx   <= dx_c;
      s2_dy   <= dy_c;
      for (int i = 0; i < 3; i++) begin
        s2_dp[i] <= P_W'(s1_x[i]) * P_W'(dy_c[i]);
        s2_ep[i] <= P_W'(s1_y[i]) * P_W'(dx_c[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_skip <= s2_skip;
      for (int i = 0; i < 3; i++) begin
        s3_nx[i] <= N_W'(s2_k[i]) * N_W'(s2_dy[i]);
        s3_ny[i] <= N_W'(s2_k[i]) * N_W'(s2_dx[i]);
      end
      s3_denx <= (DEN_W'(s2_dp[0]) + DEN_W'(s2_dp[1]) + DEN_W'(s2_dp[2])) <<< 1;
      s3_deny <= (DEN_W'(s2_ep[0]) + DEN_W'(s2_ep[1]) + DEN_W'(s2_ep[2])) <<< 1;
    end
  end

  always_comb begin
    nx_c  = s3_nx[0] + s3_nx[1] + s3_nx[2];
    ny_c  = s3_ny[0] + s3_ny[1] + s3_ny[2];
    nxa_c = nx_c[N_W-1] ? -nx_c : nx_c;
    nya_c = ny_c[N_W-1] ? -ny_c : ny_c;
    dxa_c = s3_denx[DEN_W-1] ? -s3_denx : s3_denx;
    dya_c = s3_deny[DEN_W-1] ? -s3_deny : s3_deny;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_o.nmag_x <= nxa_c[NMAG_W-1:0];
      res_o.nmag_y <= nya_c[NMAG_W-1:0];
      res_o.dmag_x <= dxa_c[DMAG_W-1:0];
      res_o.dmag_y <= dya_c[DMAG_W-1:0];
      res_o.neg_x  <= nx_c[N_W-1] ^ s3_denx[DEN_W-1];
      res_o.neg_y  <= ny_c[N_W-1] ^ s3_deny[DEN_W-1];
      if (s3_skip) begin
        res_o.st <= ST_SKIP;
      end else if ((s3_denx == '0) || (s3_deny == '0)) begin
        res_o.st <= ST_DEGEN;
      end else begin
        res_o.st <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      s1_v  <= vld_i;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      vld_o <= s3_v;
    end
  end

endmodule

/* hdl/rssi_trilateration_solver_unit.sv */
// top level of the three-anchor rssi trilateration solver
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   in      | in_valid / in_ready    | anchor1..3 x, y, rssi
//   out     | out_valid / out_ready  | pos_x, pos_y, status
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (0 slope, 1 offset)
//
// one word accepted per cycle unless the output stalls; the pipe is four
// front stages, one cell per quotient bit (51 cells, each lane has its own
// row) and one output register.
// reset clears all valid bits and loads the default slope and offset.
// a stalled output word freezes the whole pipe; in_ready follows
// !out_valid || out_ready, so a bubble in the pipe never blocks input.
// cfg_ready is always high; unknown register indexes are dropped.
module rssi_trilateration_solver_unit import rts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] anchor1_x,
  input  logic signed [COORD_W-1:0] anchor1_y,
  input  logic signed [RSSI_W-1:0]  anchor1_rssi,
  input  logic signed [COORD_W-1:0] anchor2_x,
  input  logic signed [COORD_W-1:0] anchor2_y,
  input  logic signed [RSSI_W-1:0]  anchor2_rssi,
  input  logic signed [COORD_W-1:0] anchor3_x,
  input  logic signed [COORD_W-1:0] anchor3_y,
  input  logic signed [RSSI_W-1:0]  anchor3_rssi,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [POS_W-1:0]   pos_x,
  output logic signed [POS_W-1:0]   pos_y,
  output logic [1:0]                status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam logic [NMAG_W-1:0] Q_POS_MAX = NMAG_W'(33'h0_7FFF_FFFF);
  localparam logic [NMAG_W-1:0] Q_NEG_MAX = NMAG_W'(33'h0_8000_0000);
  localparam logic [POS_W-1:0]  POS_HI    = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0]  POS_LO    = 32'h8000_0000;

  logic signed [CFG_W-1:0]   slope_q16, offset_q16;
  logic                      adv;
  logic signed [COORD_W-1:0] ax [3];
  logic signed [COORD_W-1:0] ay [3];
  logic signed [RSSI_W-1:0]  ar [3];
  logic                      fr_v;
  front_t                    fr;

  // cell rows, one per coordinate, plus valid and side info riding along
  lane_t lx [NMAG_W+1];
  lane_t ly [NMAG_W+1];
  logic  cv [NMAG_W];
  meta_t cm [NMAG_W];

  // final quotient handling
  meta_t             m_last;
  logic [NMAG_W-1:0] qx, qy;
  logic              sat_x, sat_y;
  logic [POS_W-1:0]  px_c, py_c;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_q16  <= SLOPE_RESET;
      offset_q16 <= OFFSET_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SLOPE) begin
        slope_q16 <= cfg_data;
      end else if (cfg_index == REG_OFFSET) begin
        offset_q16 <= cfg_data;
      end
    end
  end

  assign ax[0] = anchor1_x;
  assign ax[1] = anchor2_x;
  assign ax[2] = anchor3_x;
  assign ay[0] = anchor1_y;
  assign ay[1] = anchor2_y;
  assign ay[2] = anchor3_y;
  assign ar[0] = anchor1_rssi;
  assign ar[1] = anchor2_rssi;
  assign ar[2] = anchor3_rssi;

  rts_front u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .vld_i  (in_valid),
    .ax     (ax),
    .ay     (ay),
    .ar     (ar),
    .slope  (slope_q16),
    .offset (offset_q16),
    .vld_o  (fr_v),
    .res_o  (fr)
  );

  // head of each row: empty remainder, magnitude dividend, magnitude divisor
  assign lx[0] = '{rem: '0, num: fr.nmag_x, q: '0, d: fr.dmag_x};
  assign ly[0] = '{rem: '0, num: fr.nmag_y, q: '0, d: fr.dmag_y};

  for (genvar g = 0; g < NMAG_W; g++) begin : g_cell
    rts_div_cell u_cx (.clk(clk), .en(adv), .lane_i(lx[g]), .lane_o(lx[g+1]));
    rts_div_cell u_cy (.clk(clk), .en(adv), .lane_i(ly[g]), .lane_o(ly[g+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NMAG_W; i++) begin
        cv[i] <= 1'b0;
      end
    end else if (adv) begin
      cv[0] <= fr_v;
      for (int i = 1; i < NMAG_W; i++) begin
        cv[i] <= cv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cm[0] <= '{neg_x: fr.neg_x, neg_y: fr.neg_y, st: fr.st};
      for (int i = 1; i < NMAG_W; i++) begin
        cm[i] <= cm[i-1];
      end
    end
  end

  // sign restore and 32-bit clamp
  always_comb begin
    m_last = cm[NMAG_W-1];
    qx     = lx[NMAG_W].q;
    qy     = ly[NMAG_W].q;
    sat_x  = m_last.neg_x ? (qx > Q_NEG_MAX) : (qx > Q_POS_MAX);
    sat_y  = m_last.neg_y ? (qy > Q_NEG_MAX) : (qy > Q_POS_MAX);
    if (sat_x) begin
      px_c = m_last.neg_x ? POS_LO : POS_HI;
    end else begin
      px_c = m_last.neg_x ? -qx[POS_W-1:0] : qx[POS_W-1:0];
    end
    if (sat_y) begin
      py_c = m_last.neg_y ? POS_LO : POS_HI;
    end else begin
      py_c = m_last.neg_y ? -qy[POS_W-1:0] : qy[POS_W-1:0];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (m_last.st != ST_OK) begin
        pos_x  <= '0;
        pos_y  <= '0;
        status <= m_last.st;
      end else begin
        pos_x  <= px_c;
        pos_y  <= py_c;
        status <= (sat_x || sat_y) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cv[NMAG_W-1];
    end
  end

  // failed solves carry no position
  a_zero_on_fail : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_SKIP || status == ST_DEGEN) |-> pos_x == '0 && pos_y == '0)
    else $error("position not cleared on failed solve");

  // writes to unknown indexes leave both registers alone
  a_cfg_ignore : assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index != REG_SLOPE && cfg_index != REG_OFFSET
    |=> $stable(slope_q16) && $stable(offset_q16))
    else $error("config register changed by unknown index");

  // an accepted word enters the front pipe
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> u_front.s1_v)
    else $error("accepted word lost at pipe entry");

endmodule

/* tb/rssi_trilateration_solver_unit_tb.sv */
// self-checking testbench of the three-anchor rssi trilateration solver
`timescale 1ns / 100ps

module rssi_trilateration_solver_unit_tb import rts_pkg::*; ();

  localparam int LATENCY   = 56;
  localparam int CYCLE_CAP = 400000;
  localparam int N_RANDOM  = 1536;

  // one position problem as it goes into the solver
  typedef struct {
    logic signed [COORD_W-1:0] x [3];
    logic signed [COORD_W-1:0] y [3];
    logic signed [RSSI_W-1:0]  rssi [3];
  } problem_t;

  // one solved position
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [1:0]              st;
  } fix_t;

  // directed row: problem plus an optional typed-in answer
  typedef struct {
    problem_t p;
    bit       known;
    fix_t     ans;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] anchor1_x = '0, anchor1_y = '0;
  logic signed [COORD_W-1:0] anchor2_x = '0, anchor2_y = '0;
  logic signed [COORD_W-1:0] anchor3_x = '0, anchor3_y = '0;
  logic signed [RSSI_W-1:0]  anchor1_rssi = '0, anchor2_rssi = '0, anchor3_rssi = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [POS_W-1:0]   pos_x, pos_y;
  logic [1:0]                status;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  rssi_trilateration_solver_unit dut (.*);

  always #1 clk = ~clk;

  // predictor's copy of the coefficient registers
  logic signed [CFG_W-1:0] slope_m = SLOPE_RESET;
  logic signed [CFG_W-1:0] offset_m = OFFSET_RESET;

  fix_t pending_fixes [$];
  int   fail_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   recv_hold = 1'b0;

  // rssi to distance: truncate the q16 product toward zero
  function automatic logic signed [63:0] range_of(logic signed [RSSI_W-1:0] r);
    logic signed [63:0] t;
    t = 64'(slope_m) * 64'(r) + 64'(offset_m);
    return t / (64'sd1 <<< FRAC_W);
  endfunction

  // signed division toward zero, clamped to 32 bits
  function automatic logic signed [POS_W-1:0] clamp_div(logic signed [127:0] n,
                                                        logic signed [127:0] d,
                                                        ref bit sat);
    logic signed [127:0] q;
    q = n / d;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return POS_W'(q);
  endfunction

  function automatic fix_t solve_position(problem_t p);
    fix_t f;
    logic signed [127:0] x [3], y [3], k [3], dval;
    logic signed [127:0] dx32, dx13, dx21, dy32, dy13, dy21, denx, deny, nx, ny;
    bit sat;
    f = '{0, 0, ST_OK};
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      x[i] = 128'(p.x[i]);
      y[i] = 128'(p.y[i]);
    end
    if (x[0] == 0 || x[1] == 0 || x[2] == 0) begin
      f.st = ST_SKIP;
      return f;
    end
    for (int i = 0; i < 3; i++) begin
      dval = 128'(range_of(p.rssi[i]));
      k[i] = x[i] * x[i] + y[i] * y[i] - dval * dval;
    end
    dx32 = x[2] - x[1]; dx13 = x[0] - x[2]; dx21 = x[1] - x[0];
    dy32 = y[2] - y[1]; dy13 = y[0] - y[2]; dy21 = y[1] - y[0];
    denx = 2 * (x[0] * dy32 + x[1] * dy13 + x[2] * dy21);
    deny = 2 * (y[0] * dx32 + y[1] * dx13 + y[2] * dx21);
    if (denx == 0 || deny == 0) begin
      f.st = ST_DEGEN;
      return f;
    end
    nx = k[0] * dy32 + k[1] * dy13 + k[2] * dy21;
    ny = k[0] * dx32 + k[1] * dx13 + k[2] * dx21;
    f.px = clamp_div(nx, denx, sat);
    f.py = clamp_div(ny, deny, sat);
    f.st = sat ? ST_SAT : ST_OK;
    return f;
  endfunction

  function automatic problem_t mk(int x1, int y1, int r1, int x2, int y2, int r2,
                                  int x3, int y3, int r3);
    problem_t p;
    p.x = '{COORD_W'(x1), COORD_W'(x2), COORD_W'(x3)};
    p.y = '{COORD_W'(y1), COORD_W'(y2), COORD_W'(y3)};
    p.rssi = '{RSSI_W'(r1), RSSI_W'(r2), RSSI_W'(r3)};
    return p;
  endfunction

  // mostly well-formed triangles of small/medium size, some full-range noise
  function automatic problem_t random_problem();
    problem_t p;
    int span;
    case ($urandom_range(0, 9))
      0, 1:    span = 32767;
      2, 3, 4: span = 200;
      default: span = 4000;
    endcase
    for (int i = 0; i < 3; i++) begin
      if (span == 32767) begin
        p.x[i] = COORD_W'($urandom);
        p.y[i] = COORD_W'($urandom);
      end else begin
        p.x[i] = COORD_W'($urandom_range(0, 2 * span) - span);
        p.y[i] = COORD_W'($urandom_range(0, 2 * span) - span);
      end
      if (p.x[i] == 0) p.x[i] = 1;
      p.rssi[i] = RSSI_W'($urandom);
    end
    // occasional skipped anchor or collinear set
    case ($urandom_range(0, 19))
      0: p.x[$urandom_range(0, 2)] = '0;
      1: begin p.x[2] = p.x[0]; p.x[1] = p.x[0]; end
      2: begin p.y[2] = p.y[0]; p.y[1] = p.y[0]; end
      default: ;
    endcase
    return p;
  endfunction

  // valid stays up between back-to-back words, drops only while idling
  task automatic send_problem(problem_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {anchor1_x, anchor2_x, anchor3_x} <= {p.x[0], p.x[1], p.x[2]};
    {anchor1_y, anchor2_y, anchor3_y} <= {p.y[0], p.y[1], p.y[2]};
    {anchor1_rssi, anchor2_rssi, anchor3_rssi} <= {p.rssi[0], p.rssi[1], p.rssi[2]};
    do @(posedge clk); while (!in_ready);
    pending_fixes.push_back(solve_position(p));
  endtask

  // register writes only once the pipe has drained
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SLOPE) slope_m = val;
    else if (idx == REG_OFFSET) offset_m = val;
  endtask

  // receiver: random stalls, plus a long hold while recv_hold is set
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // compare each accepted word with the oldest expected fix
  always @(posedge clk) begin
    fix_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_fixes.size() == 0) begin
        $display("%0t unexpected word: x=%0d y=%0d st=%0d", $time, pos_x, pos_y, status);
        fail_count++;
      end else begin
        want = pending_fixes.pop_front();
        if (pos_x !== want.px) begin
          $display("%0t pos_x exp %0d got %0d", $time, want.px, pos_x);
          fail_count++;
        end
        if (pos_y !== want.py) begin
          $display("%0t pos_y exp %0d got %0d", $time, want.py, pos_y);
          fail_count++;
        end
        if (status !== want.st) begin
          $display("%0t status exp %0d got %0d", $time, want.st, status);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("rssi_trilateration_solver_unit regression: fail");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    fix_t zero_skip, zero_degen;
    int settle;
    zero_skip  = '{0, 0, ST_SKIP};
    zero_degen = '{0, 0, ST_DEGEN};
    // anchor x zero in each slot
    rows.push_back('{mk(0, 5, 10, 3, 4, 5, 7, 8, 9), 1, zero_skip});
    rows.push_back('{mk(1, 5, 10, 0, 4, 5, 7, 8, 9), 1, zero_skip});
    rows.push_back('{mk(1, 5, 10, 3, 4, 5, 0, 8, 9), 1, zero_skip});
    // collinear anchors give a zero denominator
    rows.push_back('{mk(1, 1, -60, 2, 2, -70, 3, 3, -80), 1, zero_degen});
    rows.push_back('{mk(5, 1, -60, 5, 2, -70, 5, 3, -80), 1, zero_degen});
    rows.push_back('{mk(1, 7, -60, 2, 7, -70, 3, 7, -80), 1, zero_degen});
    // well-formed and extreme triangles, predictor-checked
    rows.push_back('{mk(10, 0, -50, 100, 0, -60, 10, 100, -70), 0, zero_skip});
    rows.push_back('{mk(32767, -32768, 127, -32768, 32767, -128, 1, 1, 0), 0, zero_skip});
    rows.push_back('{mk(-32768, -32768, -128, 32767, -32768, 127, -32768, 32767, -1),
                     0, zero_skip});
    rows.push_back('{mk(1, 0, 127, 2, 1, 127, 1, 1, 127), 0, zero_skip});
    rows.push_back('{mk(1, 0, -128, 32767, 1, -128, 1, 2, -128), 0, zero_skip});
    rows.push_back('{mk(-1, -1, 0, 1, -1, 0, -1, 1, 0), 0, zero_skip});
    rows.push_back('{mk(-1, 21845, 85, 21845, -21846, -86, 10922, 10922, 42), 0, zero_skip});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    recv_idle_pct = 0;
    foreach (rows[i]) begin
      if (rows[i].known && solve_position(rows[i].p) != rows[i].ans) begin
        $display("%0t directed row %0d: predictor disagrees with table", $time, i);
        fail_count++;
      end
      send_problem(rows[i].p);
    end

    // coefficient extremes, including the largest distances
    write_reg(REG_SLOPE, 24'h7fffff);
    write_reg(REG_OFFSET, 24'h800000);
    for (int i = 0; i < 6; i++) send_problem(random_problem());
    write_reg(REG_SLOPE, 24'h800000);
    write_reg(REG_OFFSET, 24'h7fffff);
    for (int i = 0; i < 6; i++) send_problem(random_problem());
    // unknown index must be dropped
    write_reg(IDX_W'(2), 24'h123456);
    write_reg(REG_SLOPE, SLOPE_RESET);
    write_reg(REG_OFFSET, OFFSET_RESET);

    // long receiver hold so the pipe fills and in_ready drops
    fork
      begin
        recv_hold = 1'b1;
        repeat (150) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 90; i++) send_problem(random_problem());
        in_valid <= 1'b0;
        @(posedge clk);
      end
    join

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 23; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < N_RANDOM / 3; i++) send_problem(random_problem());
      // change coefficients between phases
      if (ph < 2) begin
        write_reg(REG_SLOPE, CFG_W'($urandom));
        write_reg(REG_OFFSET, CFG_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (pending_fixes.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < LATENCY + 8) begin
      @(posedge clk);
      settle++;
    end
    if (fail_count == 0)
      $display("rssi_trilateration_solver_unit regression: pass");
    else
      $display("rssi_trilateration_solver_unit regression: fail");
    $finish;
  end

endmodule
